[sv/esb_frame_builder_top_defines.svh]
// ----------------------------------------------------------------------------
// esb_frame_builder_top_defines.svh
// Assertion macros for the frame builder. Simulation builds get the checks,
// synthesis builds get empty bodies.
// ----------------------------------------------------------------------------
`ifndef ESB_FRAME_BUILDER_TOP_DEFINES_SVH
`define ESB_FRAME_BUILDER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// check a plain property every clock outside reset
`define ESBFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// check a same-cycle implication every clock outside reset
`define ESBFB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
// check a next-cycle implication every clock outside reset
`define ESBFB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define ESBFB_ASSERT(lbl, prop, msg)
`define ESBFB_ASSERT_IMP(lbl, ante, cons, msg)
`define ESBFB_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[sv/esbfb_pkg.sv]
// ----------------------------------------------------------------------------
// esbfb_pkg
// Shared types and constants of the frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package esbfb_pkg;

  // largest payload length that is not flagged
  localparam int MaxPayload = 32;

  // bytes emitted for one input transfer at most (address burst, or a last byte with CRC and pad)
  localparam int BurstDepth = 5;
  localparam int CountW     = $clog2(BurstDepth + 1);

  // configuration register index, taken from paddr[3]
  localparam logic RegDeviceAddress = 1'b0;

  // one received input transfer
  typedef struct packed {
    logic        last_byte;
    logic [15:0] crc_value;
    logic [5:0]  payload_length;
    logic [7:0]  data_byte;
  } item_t;

  // burst of result bytes produced by one input transfer, entry 0 goes first
  typedef struct packed {
    logic [BurstDepth-1:0][7:0] bytes;
    logic [CountW-1:0]          count;
    logic                       last;
    logic                       err;
  } burst_t;

  // result buffer status toward the input side
  typedef struct packed {
    logic              can_load;
    logic [CountW-1:0] count;
  } buf_status_t;

endpackage

`default_nettype wire

[sv/esb_frame_builder_top.sv]
// ----------------------------------------------------------------------------
// esb_frame_builder_top
// Rebuilds an over-the-air frame (address, header, shifted payload, shifted
// CRC, pad) from a received packet that arrives one byte per transfer.
// ----------------------------------------------------------------------------
//  port group     dir   content
//  s_axis_*       in    tdata: data_byte[7:0], payload_length[13:8],
//                       crc_value[29:14], zero[31:30]; tlast: last_byte
//  m_axis_*       out   tdata: out_byte; tlast: out_last; tuser: length_error
//  APB            in    device_address at byte address 0 (64-bit data)
//
//  Each input transfer yields one or five output transfers: five for byte 0
//  and the last byte of a longer packet, one for a lone last byte and all
//  others. While the output is ready they go out one per cycle, and between
//  bursts the input side sustains one byte per cycle. A byte is registered in
//  the input register, its burst in the result buffer; the input register takes
//  the next byte while a burst still drains. Reset clears position, carry and
//  the buffers; device_address resets to all ones. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module esb_frame_builder_top
  import esbfb_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  // input stream
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [31:0] s_axis_tdata_i,  // data_byte, payload_length, crc_value, pad
  input  wire         s_axis_tlast_i,
  // output stream
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // out_byte
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o,  // length_error
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

`include "esb_frame_builder_top_defines.svh"

  logic [39:0] dev_addr_q;
  item_t       in_item;
  item_t       item;
  logic        item_valid;
  logic        take;
  burst_t      burst;
  buf_status_t buf_status;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[3] == RegDeviceAddress) ? {24'd0, dev_addr_q} : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= '1;
    end else if (psel && penable && pwrite && pready && paddr[3] == RegDeviceAddress) begin
      dev_addr_q <= pwdata[39:0];
    end
  end

  // unpack the input transfer
  assign in_item.data_byte      = s_axis_tdata_i[7:0];
  assign in_item.payload_length = s_axis_tdata_i[13:8];
  assign in_item.crc_value      = s_axis_tdata_i[29:14];
  assign in_item.last_byte      = s_axis_tlast_i;

  assign take = item_valid && buf_status.can_load;

  esbfb_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (in_item),
    .take_ok_i   (buf_status.can_load),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  esbfb_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .item_i    (item),
    .dev_addr_i(dev_addr_q),
    .burst_o   (burst)
  );

  esbfb_burst_buf u_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (take),
    .burst_i    (burst),
    .status_o   (buf_status),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_byte_o (m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o),
    .out_err_o  (m_axis_tuser_o)
  );

  // checks
  `ESBFB_ASSERT_IMP(a_last_is_pad, m_axis_tvalid_o && m_axis_tlast_o, m_axis_tdata_o == 8'd0, "frame end byte is not a zero pad")
  `ESBFB_ASSERT(a_count_range, buf_status.count <= CountW'(BurstDepth), "burst count out of range")
  `ESBFB_ASSERT_IMP(a_load_nonempty, take, burst.count == CountW'(1) || burst.count == CountW'(BurstDepth), "burst size is neither one nor five")
  `ESBFB_ASSERT_NXT(a_load_shows, take, m_axis_tvalid_o, "loaded burst not presented")

endmodule

`default_nettype wire

[sv/esbfb_in_reg.sv]
// ----------------------------------------------------------------------------
// esbfb_in_reg
// Input register: holds one accepted transfer until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module esbfb_in_reg
  import esbfb_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire item_t in_item_i,
  input  wire        take_ok_i,
  output logic       item_valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  // hand the held item on when the result buffer can load
  assign take         = valid_q && take_ok_i;
  assign in_ready_o   = !valid_q || take_ok_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (take) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // capture payload on every input transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

[sv/esbfb_core.sv]
// ----------------------------------------------------------------------------
// esbfb_core
// Packet position and carry state; builds the result burst for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module esbfb_core
  import esbfb_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         take_i,
  input  wire item_t  item_i,
  input  wire  [39:0] dev_addr_i,
  output burst_t      burst_o
);

  logic [5:0]  pos_q, pos_d;
  logic        carry_q, carry_d;
  logic        plen_err;
  logic        idx_err;
  logic        new_carry;
  logic [15:0] crc;

  assign crc       = item_i.crc_value;
  assign new_carry = item_i.data_byte[0];
  assign plen_err  = {1'b0, item_i.payload_length} > 7'(MaxPayload);
  assign idx_err   = {1'b0, pos_q} >= 7'(MaxPayload + 2);

  // build the burst and the next state
  always_comb begin
    burst_o       = '0;
    pos_d         = pos_q;
    carry_d       = carry_q;
    burst_o.err   = plen_err;
    if (pos_q == 6'd0) begin
      if (item_i.last_byte) begin
        // packet under two bytes: lone flagged pad byte
        burst_o.count = CountW'(1);
        burst_o.last  = 1'b1;
        burst_o.err   = 1'b1;
        pos_d         = 6'd0;
        carry_d       = 1'b0;
      end else begin
        // address bytes, most significant first
        for (int i = 0; i < BurstDepth; i++) begin
          burst_o.bytes[i] = dev_addr_i[8*(BurstDepth-1-i) +: 8];
        end
        burst_o.count = CountW'(BurstDepth);
        pos_d         = 6'd1;
        carry_d       = 1'b0;
      end
    end else begin
      if (pos_q == 6'd1) begin
        // header: length and packet id
        burst_o.bytes[0] = {item_i.payload_length, item_i.data_byte[2:1]};
        pos_d            = 6'd2;
      end else begin
        // payload byte, shifted behind the carried bit
        burst_o.bytes[0] = {carry_q, item_i.data_byte[7:1]};
        burst_o.err      = plen_err || idx_err;
        if (pos_q != 6'd63) begin
          pos_d = pos_q + 6'd1;
        end
      end
      carry_d       = new_carry;
      burst_o.count = CountW'(1);
      if (item_i.last_byte) begin
        // CRC shifted the same way, then a zero pad
        burst_o.bytes[1] = {new_carry, crc[15:9]};
        burst_o.bytes[2] = {crc[8], crc[7:1]};
        burst_o.bytes[3] = {crc[0], 7'd0};
        burst_o.bytes[4] = 8'd0;
        burst_o.count    = CountW'(BurstDepth);
        burst_o.last     = 1'b1;
        pos_d            = 6'd0;
        carry_d          = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 6'd0;
      carry_q <= 1'b0;
    end else if (take_i) begin
      pos_q   <= pos_d;
      carry_q <= carry_d;
    end
  end

endmodule

`default_nettype wire

[sv/esbfb_burst_buf.sv]
// ----------------------------------------------------------------------------
// esbfb_burst_buf
// Result register: holds one burst and shifts it out one byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module esbfb_burst_buf
  import esbfb_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          load_i,
  input  wire burst_t  burst_i,
  output buf_status_t  status_o,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output logic [7:0]   out_byte_o,
  output logic         out_last_o,
  output logic         out_err_o
);

  logic [CountW-1:0]          cnt_q, cnt_d;
  logic [BurstDepth-1:0][7:0] bytes_q, bytes_d;
  logic                       last_q;
  logic                       err_q;
  logic                       pop;

  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_byte_o  = bytes_q[0];
  assign out_last_o  = last_q && (cnt_q == CountW'(1));
  assign out_err_o   = err_q;

  // free for a new burst once the last byte leaves
  assign status_o.can_load = !out_valid_o || (pop && cnt_q == CountW'(1));
  assign status_o.count    = cnt_q;

  always_comb begin
    cnt_d   = cnt_q;
    bytes_d = bytes_q;
    if (load_i) begin
      cnt_d   = burst_i.count;
      bytes_d = burst_i.bytes;
    end else if (pop) begin
      cnt_d = cnt_q - CountW'(1);
      // advance the queue toward entry 0
      for (int i = 0; i < BurstDepth - 1; i++) begin
        bytes_d[i] = bytes_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    if (load_i) begin
      last_q <= burst_i.last;
      err_q  <= burst_i.err;
    end
  end

endmodule

`default_nettype wire

[tb/sv/esb_frame_checker.sv]
// ----------------------------------------------------------------------------
// esb_frame_checker
// Watches the input stream, the output stream and the register port of the
// frame builder. Predicts every output byte from the accepted input
// transfers and compares it field by field with the output transfers.
// ----------------------------------------------------------------------------
module esb_frame_checker
  import esbfb_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  // input stream
  input  wire         s_tvalid_i,
  input  wire         s_tready_i,
  input  wire  [31:0] s_tdata_i,   // data_byte, payload_length, crc_value, zero
  input  wire         s_tlast_i,
  // output stream
  input  wire         m_tvalid_i,
  input  wire         m_tready_i,
  input  wire  [7:0]  m_tdata_i,   // out_byte
  input  wire         m_tlast_i,
  input  wire         m_tuser_i,   // length_error
  // register port
  input  wire         apb_psel_i,
  input  wire         apb_penable_i,
  input  wire         apb_pwrite_i,
  input  wire  [3:0]  apb_paddr_i,
  input  wire  [63:0] apb_pwdata_i,
  input  wire         apb_pready_i,
  // status toward the stimulus side
  output int          mismatch_count_o,
  output int          bytes_owed_o,
  output int          items_seen_o,
  output int          packets_seen_o,
  output int          bytes_seen_o,
  output int          flagged_seen_o
);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       length_error;
  } frame_byte_t;

  // predicted frame bytes, oldest first
  frame_byte_t frame_q[$];

  // shadow of the block state and its register
  logic [39:0] dev_addr;
  logic [5:0]  byte_pos;
  logic        carry;

  item_t       rx_item;
  frame_byte_t want;

  function automatic void push_byte(logic [7:0] b, logic l, logic e);
    frame_byte_t fb;
    fb.out_byte     = b;
    fb.out_last     = l;
    fb.length_error = e;
    frame_q.push_back(fb);
  endfunction

  // work out the frame bytes that one received byte causes
  task automatic build_frame_bytes(input item_t it);
    logic       err;
    logic [7:0] hi;
    logic [7:0] lo;
    err = (it.payload_length > MaxPayload);
    hi  = it.crc_value[15:8];
    lo  = it.crc_value[7:0];
    if (byte_pos == 6'd0) begin
      if (it.last_byte) begin
        // packet ended before the header: lone flagged pad byte
        push_byte(8'h00, 1'b1, 1'b1);
        carry = 1'b0;
      end else begin
        for (int i = 4; i >= 0; i--) begin
          push_byte(dev_addr[8*i +: 8], 1'b0, err);
        end
        byte_pos = 6'd1;
        carry    = 1'b0;
      end
    end else begin
      if (byte_pos == 6'd1) begin
        // header: length above the packet id
        push_byte({it.payload_length, it.data_byte[2:1]}, 1'b0, err);
        carry    = it.data_byte[0];
        byte_pos = 6'd2;
      end else begin
        // payload byte beyond the maximum is flagged
        err = err || ((int'(byte_pos) - 2) >= MaxPayload);
        push_byte({carry, it.data_byte[7:1]}, 1'b0, err);
        carry = it.data_byte[0];
        if (byte_pos < 6'd63) begin
          byte_pos = byte_pos + 6'd1;
        end
      end
      if (it.last_byte) begin
        // shifted CRC in three bytes, then the pad byte
        push_byte({carry, hi[7:1]}, 1'b0, err);
        push_byte({hi[0], lo[7:1]}, 1'b0, err);
        push_byte({lo[0], 7'd0}, 1'b0, err);
        push_byte(8'h00, 1'b1, err);
        byte_pos = 6'd0;
        carry    = 1'b0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q.delete();
      dev_addr         = 40'hFF_FFFF_FFFF;
      byte_pos         = 6'd0;
      carry            = 1'b0;
      mismatch_count_o = 0;
      bytes_owed_o     = 0;
      items_seen_o     = 0;
      packets_seen_o   = 0;
      bytes_seen_o     = 0;
      flagged_seen_o   = 0;
    end else begin
      // compare an output transfer with the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        bytes_seen_o++;
        if (m_tuser_i) begin
          flagged_seen_o++;
        end
        if (frame_q.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: unexpected output byte, expected none, actual %h last %b err %b",
                   $time, m_tdata_i, m_tlast_i, m_tuser_i);
        end else begin
          want = frame_q.pop_front();
          if (m_tdata_i !== want.out_byte) begin
            mismatch_count_o++;
            $display("%0t: out_byte mismatch, expected %h actual %h",
                     $time, want.out_byte, m_tdata_i);
          end
          if (m_tlast_i !== want.out_last) begin
            mismatch_count_o++;
            $display("%0t: out_last mismatch, expected %b actual %b",
                     $time, want.out_last, m_tlast_i);
          end
          if (m_tuser_i !== want.length_error) begin
            mismatch_count_o++;
            $display("%0t: length_error mismatch, expected %b actual %b",
                     $time, want.length_error, m_tuser_i);
          end
        end
      end
      // predict from an input transfer
      if (s_tvalid_i && s_tready_i) begin
        items_seen_o++;
        if (s_tlast_i) begin
          packets_seen_o++;
        end
        rx_item.data_byte      = s_tdata_i[7:0];
        rx_item.payload_length = s_tdata_i[13:8];
        rx_item.crc_value      = s_tdata_i[29:14];
        rx_item.last_byte      = s_tlast_i;
        build_frame_bytes(rx_item);
      end
      // track register writes
      if (apb_psel_i && apb_penable_i && apb_pwrite_i && apb_pready_i &&
          apb_paddr_i[3] == RegDeviceAddress) begin
        dev_addr = apb_pwdata_i[39:0];
      end
      bytes_owed_o = frame_q.size();
    end
  end

endmodule

[tb/sv/tb_esb_frame_builder_top.sv]
// ----------------------------------------------------------------------------
// tb_esb_frame_builder_top
// Drives received packets into the frame builder under changing device
// addresses and idle patterns; a checker beside the block predicts and
// compares every rebuilt frame byte. Directed packets first, then random.
// ----------------------------------------------------------------------------
module tb_esb_frame_builder_top;
  import esbfb_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_tvalid      = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata       = 32'd0;  // data_byte, payload_length, crc_value, zero
  logic        s_tlast       = 1'b0;
  logic        m_tvalid;
  logic        m_tready      = 1'b0;
  logic [7:0]  m_tdata;                // out_byte
  logic        m_tlast;
  logic        m_tuser;                // length_error
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = 4'd0;
  logic [63:0] pwdata        = 64'd0;
  logic [63:0] prdata;
  logic        pready;

  int mismatch_count;
  int bytes_owed;
  int items_seen;
  int packets_seen;
  int bytes_seen;
  int flagged_seen;

  int tx_idle_pct = 16;
  int rx_idle_pct = 47;
  int rnd_items   = 0;
  int addr_writes = 0;
  int pick;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  esb_frame_builder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  esb_frame_checker u_frame_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_tvalid),
    .s_tready_i       (s_tready),
    .s_tdata_i        (s_tdata),
    .s_tlast_i        (s_tlast),
    .m_tvalid_i       (m_tvalid),
    .m_tready_i       (m_tready),
    .m_tdata_i        (m_tdata),
    .m_tlast_i        (m_tlast),
    .m_tuser_i        (m_tuser),
    .apb_psel_i       (psel),
    .apb_penable_i    (penable),
    .apb_pwrite_i     (pwrite),
    .apb_paddr_i      (paddr),
    .apb_pwdata_i     (pwdata),
    .apb_pready_i     (pready),
    .mismatch_count_o (mismatch_count),
    .bytes_owed_o     (bytes_owed),
    .items_seen_o     (items_seen),
    .packets_seen_o   (packets_seen),
    .bytes_seen_o     (bytes_seen),
    .flagged_seen_o   (flagged_seen)
  );

  // stall the output side at random
  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // offer one received byte after a random gap, hold until the transfer
  task automatic send_item(input logic [7:0] d, input logic [5:0] plen,
                           input logic [15:0] crc, input logic lst);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, crc, plen, d};
    s_tlast  <= lst;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  // drop valid and hold until every predicted byte has come out
  task automatic drain_frames();
    s_tvalid <= 1'b0;
    while (bytes_owed != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // register write: setup cycle, then access cycle
  task automatic write_device_address(input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegDeviceAddress, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    addr_writes++;
  endtask

  // pick a fresh address between packets, extremes included
  task automatic reconfigure();
    logic [39:0] addr;
    drain_frames();
    case ($urandom_range(0, 3))
      0:       addr = 40'h00_0000_0000;
      1:       addr = 40'hFF_FFFF_FFFF;
      default: addr = {8'($urandom), 32'($urandom)};
    endcase
    write_device_address({24'($urandom), addr});
  endtask

  // one well-formed packet with random content and mostly matching length
  task automatic send_random_packet(input int payload_n, input bit lone);
    int          n;
    logic [5:0]  base_plen;
    logic [5:0]  plen;
    n = lone ? 1 : payload_n + 2;
    if ($urandom_range(0, 99) < 80) begin
      base_plen = (payload_n > 63) ? 6'd63 : 6'(payload_n);
    end else begin
      base_plen = 6'($urandom_range(0, 63));
    end
    for (int i = 0; i < n; i++) begin
      plen = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : base_plen;
      send_item(8'($urandom), plen, 16'($urandom), i == n - 1);
    end
    rnd_items += n;
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset address, lone byte, header-only packet
    send_item(8'h5A, 6'd0, 16'h0000, 1'b1);
    send_item(8'h00, 6'd0, 16'h0000, 1'b0);
    send_item(8'hFF, 6'd0, 16'hFFFF, 1'b1);
    drain_frames();
    write_device_address(64'h0);
    send_item(8'hFF, 6'd3, 16'hFFFF, 1'b0);
    send_item(8'h01, 6'd3, 16'h0000, 1'b0);
    send_item(8'h00, 6'd3, 16'hFFFF, 1'b0);
    send_item(8'hFF, 6'd3, 16'h0000, 1'b0);
    send_item(8'hA5, 6'd3, 16'h0000, 1'b1);
    drain_frames();
    write_device_address(64'hFFFF_FFA5_5AC3_3C0F);
    // length at the maximum, just above it and at the field limit
    send_item(8'h00, 6'd32, 16'h0000, 1'b0);
    send_item(8'h04, 6'd32, 16'h0000, 1'b0);
    send_item(8'h80, 6'd32, 16'h0000, 1'b0);
    send_item(8'h7F, 6'd32, 16'h8001, 1'b1);
    send_item(8'h11, 6'd33, 16'h0000, 1'b0);
    send_item(8'h03, 6'd33, 16'h0000, 1'b0);
    send_item(8'h55, 6'd33, 16'h7FFE, 1'b1);
    send_item(8'h00, 6'd63, 16'h0000, 1'b0);
    send_item(8'h06, 6'd63, 16'h0000, 1'b0);
    send_item(8'hAA, 6'd63, 16'hFFFF, 1'b1);
    drain_frames();
    write_device_address(64'h0000_00FF_FFFF_FFFF);
    send_item(8'h00, 6'd1, 16'h0000, 1'b0);
    send_item(8'h00, 6'd1, 16'h1234, 1'b1);
    send_item(8'hFF, 6'd63, 16'hFFFF, 1'b1);

    // random: one long packet to reach the saturated position, then a mix
    send_random_packet(70, 1'b0);
    while (rnd_items < 400) begin
      if (rnd_items >= 280 && tx_idle_pct != 0) begin
        reconfigure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (rnd_items >= 140 && tx_idle_pct == 16) begin
        reconfigure();
        tx_idle_pct = 47;
        rx_idle_pct = 16;
      end
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_random_packet(0, 1'b1);
      end else if (pick < 14) begin
        send_random_packet(0, 1'b0);
      end else if (pick < 17) begin
        send_random_packet($urandom_range(60, 70), 1'b0);
      end else if (pick < 22) begin
        send_random_packet($urandom_range(30, 34), 1'b0);
      end else begin
        send_random_packet($urandom_range(1, 12), 1'b0);
      end
      if ($urandom_range(0, 9) == 0) begin
        reconfigure();
      end
    end

    drain_frames();
    repeat (10) @(negedge clk_i);
    if (bytes_owed != 0) begin
      $display("%0t: %0d predicted bytes never came out", $time, bytes_owed);
    end
    $display("Covered %0d input transfers in %0d packets under %0d address writes.",
             items_seen, packets_seen, addr_writes);
    $display("Checked %0d frame bytes, %0d of them flagged with a length error.",
             bytes_seen, flagged_seen);
    if (mismatch_count == 0 && bytes_owed == 0) begin
      $display("PASS esb_frame_builder_top");
    end else begin
      $display("FAIL esb_frame_builder_top");
    end
    $finish;
  end

  // end a hung run
  initial begin
    #3000000;
    $display("FAIL esb_frame_builder_top");
    $finish;
  end

endmodule
